@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ESE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ESE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ese_pkg.sv @@
// Package for the encoder speed estimator: widths, register indexes, reset values.
// No dependencies.
package ese_pkg;

  localparam int ANGLE_BITS = 14;
  localparam int WORD_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int ANGLE_W    = 14;
  localparam int SPEED_W    = 28;
  localparam int RPM_W      = 22;
  localparam int ALPHA_W    = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 22;

  localparam int DELTA_W = ANGLE_BITS + 1;
  localparam int DIFF_W  = ANGLE_BITS + 2;
  localparam int MUL_P_W = SPEED_W + RPM_W + 1;
  localparam int PROD_W  = 46;

  localparam int RAW_SHIFT  = 8;
  localparam int FILT_SHIFT = 16;

  localparam logic [RPM_W-1:0]   RPM_RESET   = RPM_W'(24000);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(13107);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_RPM   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ALPHA = CFG_ADDR_W'(1);

endpackage

@@ design/ese_if.sv @@
// Valid/ready channel interfaces for the encoder speed estimator.
// Depends on ese_pkg for field widths.
interface ese_in_if import ese_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] angle_high_byte;
  logic [BYTE_W-1:0] angle_low_byte;

  modport source (output valid, output angle_high_byte, output angle_low_byte, input ready);
  modport sink   (input valid, input angle_high_byte, input angle_low_byte, output ready);
endinterface

interface ese_out_if import ese_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ANGLE_W-1:0]        angle;
  logic signed [SPEED_W-1:0] raw_speed_q8;
  logic signed [SPEED_W-1:0] filtered_speed_q8;
  logic                      speed_valid;

  modport source (output valid, output angle, output raw_speed_q8,
                  output filtered_speed_q8, output speed_valid, input ready);
  modport sink   (input valid, input angle, input raw_speed_q8,
                  input filtered_speed_q8, input speed_valid, output ready);
endinterface

@@ design/encoder_speed_estimator.sv @@
// Encoder speed estimator top level: angle unwrap, rpm scaling and IIR low-pass.
// Depends on ese_pkg and the channel interfaces in ese_if.sv.
//
// A transaction on in_ch carries the two angle bytes of one encoder read. The
// block takes one transaction while idle, then steps through S_SPEED, S_OLD,
// S_NEW and S_SUM and delivers its result to the output register in S_SUM; it
// takes no new transaction until it is back in S_IDLE. The sequence of steps is
// set by the single 28x23 signed multiplier, used three times per transaction
// (speed scaling, old-speed weight, new-speed weight) followed by one sum and
// round. A result waiting on out_ch does not block the next input transaction;
// only the final step waits for a free output register. The first transaction
// after reset only records the angle and reports zero speed with speed_valid low.
// cfg_* writes are taken at any edge with cfg_we high; out-of-range indexes are
// ignored. Alpha above 65536 acts as 65536.
module encoder_speed_estimator import ese_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ese_in_if.sink                in_ch,
  ese_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_SPEED, S_OLD, S_NEW, S_SUM} state_t;

  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(1 << (ANGLE_BITS - 1));
  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(1 << ANGLE_BITS);
  localparam logic signed [PROD_W-1:0] RAW_HALF  = PROD_W'(1 << (RAW_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] FILT_HALF = PROD_W'(1 << (FILT_SHIFT - 1));

  state_t                     state_r;
  logic [RPM_W-1:0]           rpm_r;
  logic [ALPHA_W-1:0]         alpha_r;
  logic [ANGLE_BITS-1:0]      prev_angle_r;
  logic                       awaiting_r;
  logic                       first_r;
  logic signed [DELTA_W-1:0]  delta_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic signed [SPEED_W-1:0]  raw_r;
  logic signed [SPEED_W-1:0]  filt_r;
  logic                       out_valid_r;
  logic [ANGLE_W-1:0]         out_angle_r;
  logic signed [SPEED_W-1:0]  out_raw_r;
  logic signed [SPEED_W-1:0]  out_filt_r;
  logic                       out_speed_valid_r;
  logic [ANGLE_W-1:0]         cur_angle_r;

  logic [WORD_W-1:0]          word;
  logic [ANGLE_BITS-1:0]      angle_in;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   diff_wrap;
  logic [ALPHA_W-1:0]         alpha_eff;
  logic [ALPHA_W-1:0]         alpha_rest;
  logic signed [SPEED_W-1:0]  mul_a;
  logic [RPM_W-1:0]           mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [SPEED_W-1:0]  raw_nxt;
  logic signed [PROD_W-1:0]   filt_sum;
  logic signed [SPEED_W-1:0]  filt_nxt;
  logic                       in_fire;
  logic                       out_free;

  assign in_fire  = in_ch.valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // Angle unwrap
  always_comb begin
    word     = {in_ch.angle_high_byte, in_ch.angle_low_byte};
    angle_in = word[WORD_W-1 -: ANGLE_BITS];
    diff     = $signed({2'b00, angle_in}) - $signed({2'b00, prev_angle_r});
    if (diff < -HALF_TURN) begin
      diff_wrap = diff + FULL_TURN;
    end else if (diff > HALF_TURN) begin
      diff_wrap = diff - FULL_TURN;
    end else begin
      diff_wrap = diff;
    end
  end

  // Shared multiplier
  always_comb begin
    alpha_eff  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    alpha_rest = ALPHA_ONE - alpha_eff;
    case (state_r)
      S_SPEED: begin
        mul_a = SPEED_W'(delta_r);
        mul_b = rpm_r;
      end
      S_NEW: begin
        mul_a = raw_r;
        mul_b = RPM_W'(alpha_eff);
      end
      default: begin
        mul_a = filt_r;
        mul_b = RPM_W'(alpha_rest);
      end
    endcase
    mul_p    = mul_a * $signed({1'b0, mul_b});
    raw_nxt  = SPEED_W'((prod_r + RAW_HALF) >>> RAW_SHIFT);
    filt_sum = acc_r + prod_r;
    filt_nxt = SPEED_W'(filt_sum >>> FILT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rpm_r        <= RPM_RESET;
      alpha_r      <= ALPHA_RESET;
      prev_angle_r <= '0;
      awaiting_r   <= 1'b1;
      filt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_IDX_RPM:   rpm_r   <= cfg_wdata[RPM_W-1:0];
          CFG_IDX_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
          default:       ;
        endcase
      end

      // S_SUM drives out_valid_r itself
      if (out_valid_r && out_ch.ready && (state_r != S_SUM)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cur_angle_r  <= ANGLE_W'(angle_in);
            delta_r      <= DELTA_W'(diff_wrap);
            prev_angle_r <= angle_in;
            first_r      <= awaiting_r;
            awaiting_r   <= 1'b0;
            state_r      <= S_SPEED;
          end
        end
        S_SPEED: begin
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_OLD;
        end
        S_OLD: begin
          raw_r   <= raw_nxt;
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_NEW;
        end
        S_NEW: begin
          acc_r   <= prod_r + FILT_HALF;
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_angle_r       <= cur_angle_r;
            out_speed_valid_r <= !first_r;
            if (first_r) begin
              filt_r     <= '0;
              out_raw_r  <= '0;
              out_filt_r <= '0;
            end else begin
              filt_r     <= filt_nxt;
              out_raw_r  <= raw_r;
              out_filt_r <= filt_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.angle             = out_angle_r;
  assign out_ch.raw_speed_q8      = out_raw_r;
  assign out_ch.filtered_speed_q8 = out_filt_r;
  assign out_ch.speed_valid       = out_speed_valid_r;

endmodule

@@ design/ese_checker.sv @@
// Port-level checker for the encoder speed estimator, bound to the top level.
// Depends on ese_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ese_checker import ese_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ANGLE_W-1:0]        out_angle,
  input logic signed [SPEED_W-1:0] out_raw,
  input logic signed [SPEED_W-1:0] out_filt,
  input logic                      out_speed_valid
);

  `ESE_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken while busy")
  `ESE_ASSERT(a_first_zero, out_valid && !out_speed_valid |-> out_raw == '0 && out_filt == '0, "nonzero speed on first sample")
  `ESE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_raw) && $stable(out_filt), "stalled result changed")
  `ESE_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind encoder_speed_estimator ese_checker u_ese_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_angle       (out_ch.angle),
  .out_raw         (out_ch.raw_speed_q8),
  .out_filt        (out_ch.filtered_speed_q8),
  .out_speed_valid (out_ch.speed_valid)
);
